// ===== sv/cqd_pkg.sv =====
// Shared types and codes for the circular queue with duplicate removal.
`default_nettype none

package cqd_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [1:0] OP_ENQ   = 2'd0;
    localparam logic [1:0] OP_DEQ   = 2'd1;
    localparam logic [1:0] OP_DEDUP = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic        [1:0]  opcode;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] value_res;
        logic        [1:0]  status;
        logic        [4:0]  count;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;      // command transfer taken, latch the value
        logic enq;
        logic deq;
        logic noop;
        logic dd_empty;  // dedup on an empty queue
        logic dd_init;
        logic rd_elem;   // read next source word
        logic cap;       // capture source word, read kept[0]
        logic cmp_step;  // no match yet, read next kept word
        logic keep;      // append captured word to kept bank
        logic adv;       // step to next source word
        logic fin;       // swap banks, report
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic kept_zero;
        logic match;
        logic k_last;
        logic n_last;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== sv/cqd_ctrl.sv =====
// Controller state machine: command decode and the dedup walk sequence.
`default_nettype none

module cqd_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [1:0]       i_opcode,
    input  wire cqd_pkg::t_dp_sts i_sts,
    output logic                  o_busy,
    output cqd_pkg::t_dp_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CAP  = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_KEEP = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] r_state, n_state;
    logic [1:0] r_op, n_op;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state    = S_EXEC;
                    n_op       = i_opcode;
                    o_cmd.load = 1'b1;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                unique case (r_op)
                    cqd_pkg::OP_ENQ: o_cmd.enq = 1'b1;
                    cqd_pkg::OP_DEQ: o_cmd.deq = 1'b1;
                    cqd_pkg::OP_DEDUP: begin
                        if (i_sts.empty) begin
                            o_cmd.dd_empty = 1'b1;
                        end else begin
                            o_cmd.dd_init = 1'b1;
                            n_state       = S_RD;
                        end
                    end
                    default: o_cmd.noop = 1'b1;
                endcase
            end
            S_RD: begin
                o_cmd.rd_elem = 1'b1;
                n_state       = S_CAP;
            end
            S_CAP: begin
                o_cmd.cap = 1'b1;
                n_state   = i_sts.kept_zero ? S_KEEP : S_CMP;
            end
            S_CMP: begin
                priority if (i_sts.match) begin
                    o_cmd.adv = 1'b1;
                    n_state   = i_sts.n_last ? S_FIN : S_RD;
                end else if (i_sts.k_last) begin
                    n_state = S_KEEP;
                end else begin
                    o_cmd.cmp_step = 1'b1;
                end
            end
            S_KEEP: begin
                o_cmd.keep = 1'b1;
                o_cmd.adv  = 1'b1;
                n_state    = i_sts.n_last ? S_FIN : S_RD;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= cqd_pkg::OP_ENQ;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== sv/cqd_dp.sv =====
// Datapath: banked word store, queue pointers, dedup counters, result register.
`default_nettype none

module cqd_dp #(
    parameter int DEPTH      = cqd_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cqd_pkg::DATA_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire cqd_pkg::t_dp_cmd   i_cmd,
    input  wire logic signed [31:0] i_value,
    output cqd_pkg::t_dp_sts        o_sts,
    output logic                    o_strobe,
    output cqd_pkg::t_out_item      o_out
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [FW-1:0] FULL_FILL = FW'(DEPTH);

    // two banks: live queue and dedup target, swapped when dedup ends
    logic [DATA_WIDTH-1:0] r_mem [0:1][0:DEPTH-1];
    logic [DATA_WIDTH-1:0] r_rdata;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [DATA_WIDTH-1:0] r_cur, n_cur;

    logic          r_bank, n_bank;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_k, n_k;
    logic [FW-1:0] r_fill, n_fill;
    logic [FW-1:0] r_n, n_n;
    logic [FW-1:0] r_kept, n_kept;

    logic               r_strobe, n_strobe;
    cqd_pkg::t_out_item r_out, n_out;

    logic                  rd_bank;
    logic [AW-1:0]         rd_ptr;
    logic                  wr_en;
    logic                  wr_bank;
    logic [AW-1:0]         wr_ptr;
    logic [DATA_WIDTH-1:0] wr_data;

    logic [AW-1:0] head_inc, tail_inc, idx_inc;
    logic          full;

    assign head_inc = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == LAST_SLOT) ? '0 : r_tail + 1'b1;
    assign idx_inc  = (r_idx == LAST_SLOT) ? '0 : r_idx + 1'b1;
    assign full     = (r_fill == FULL_FILL);

    assign o_sts.empty     = (r_fill == '0);
    assign o_sts.kept_zero = (r_kept == '0);
    assign o_sts.match     = (r_rdata == r_cur);
    assign o_sts.k_last    = ((FW'(r_k) + FW'(1)) == r_kept);
    assign o_sts.n_last    = ((r_n + FW'(1)) == r_fill);

    // read port: head word by default so a dequeue finds it ready
    always_comb begin
        rd_bank = r_bank;
        rd_ptr  = r_head;
        priority if (i_cmd.cap) begin
            rd_bank = ~r_bank;
            rd_ptr  = '0;
        end else if (i_cmd.cmp_step) begin
            rd_bank = ~r_bank;
            rd_ptr  = r_k + 1'b1;
        end else if (i_cmd.rd_elem) begin
            rd_ptr = r_idx;
        end else begin
            rd_ptr = r_head;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_bank = r_bank;
        wr_ptr  = r_tail;
        wr_data = r_val;
        if (i_cmd.enq && !full) begin
            wr_en = 1'b1;
        end else if (i_cmd.keep) begin
            wr_en   = 1'b1;
            wr_bank = ~r_bank;
            wr_ptr  = r_kept[AW-1:0];
            wr_data = r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_bank][wr_ptr] <= wr_data;
        end
        r_rdata <= r_mem[rd_bank][rd_ptr];
    end

    always_comb begin
        n_val    = r_val;
        n_cur    = r_cur;
        n_bank   = r_bank;
        n_head   = r_head;
        n_tail   = r_tail;
        n_idx    = r_idx;
        n_k      = r_k;
        n_fill   = r_fill;
        n_n      = r_n;
        n_kept   = r_kept;
        n_strobe = 1'b0;
        n_out    = r_out;

        if (i_cmd.load) begin
            n_val = DATA_WIDTH'($unsigned(i_value));
        end

        if (i_cmd.enq) begin
            n_strobe        = 1'b1;
            n_out.value_res = '0;
            if (full) begin
                n_out.status = cqd_pkg::ST_FULL;
                n_out.count  = 5'(r_fill);
            end else begin
                n_tail       = tail_inc;
                n_fill       = r_fill + FW'(1);
                n_out.status = cqd_pkg::ST_OK;
                n_out.count  = 5'(r_fill + FW'(1));
            end
        end

        if (i_cmd.deq) begin
            n_strobe = 1'b1;
            if (r_fill == '0) begin
                n_out.value_res = '0;
                n_out.status    = cqd_pkg::ST_EMPTY;
                n_out.count     = '0;
            end else begin
                n_out.value_res = 32'(r_rdata);
                n_out.status    = cqd_pkg::ST_OK;
                n_head          = head_inc;
                n_fill          = r_fill - FW'(1);
                n_out.count     = 5'(r_fill - FW'(1));
            end
        end

        if (i_cmd.noop) begin
            n_strobe        = 1'b1;
            n_out.value_res = '0;
            n_out.status    = cqd_pkg::ST_OK;
            n_out.count     = 5'(r_fill);
        end

        if (i_cmd.dd_empty) begin
            n_strobe        = 1'b1;
            n_out.value_res = '0;
            n_out.status    = cqd_pkg::ST_EMPTY;
            n_out.count     = '0;
        end

        if (i_cmd.dd_init) begin
            n_idx  = r_head;
            n_n    = '0;
            n_kept = '0;
        end

        if (i_cmd.cap) begin
            n_cur = r_rdata;
            n_k   = '0;
        end

        if (i_cmd.cmp_step) begin
            n_k = r_k + 1'b1;
        end

        if (i_cmd.keep) begin
            n_kept = r_kept + FW'(1);
        end

        if (i_cmd.adv) begin
            n_idx = idx_inc;
            n_n   = r_n + FW'(1);
        end

        if (i_cmd.fin) begin
            n_bank          = ~r_bank;
            n_head          = '0;
            n_tail          = (r_kept == FULL_FILL) ? '0 : r_kept[AW-1:0];
            n_fill          = r_kept;
            n_strobe        = 1'b1;
            n_out.value_res = '0;
            n_out.status    = cqd_pkg::ST_OK;
            n_out.count     = 5'(r_kept);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank   <= 1'b0;
            r_head   <= '0;
            r_tail   <= '0;
            r_fill   <= '0;
            r_idx    <= '0;
            r_k      <= '0;
            r_n      <= '0;
            r_kept   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_bank   <= n_bank;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_fill   <= n_fill;
            r_idx    <= n_idx;
            r_k      <= n_k;
            r_n      <= n_n;
            r_kept   <= n_kept;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_cur <= n_cur;
        r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

    // occupancy bound
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_FILL)
        else $error("fill above depth");

    // empty or full queue has head and tail on the same slot
    a_ptr_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0 || r_fill == FULL_FILL) |-> (r_head == r_tail))
        else $error("head and tail disagree with fill");

    // results never come back to back, as every command starts from idle
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe)
        else $error("results on consecutive cycles");

    // full status only reported with the queue at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_out.status == cqd_pkg::ST_FULL) |-> (r_out.count == 5'(DEPTH)))
        else $error("full status with wrong count");

    // a dedup walk never keeps more words than it has visited
    a_kept_le_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.keep |-> (r_kept <= r_n))
        else $error("kept count ahead of walk");

endmodule

`default_nettype wire

// ===== sv/circular_queue_with_dedup_top.sv =====
// Top level of the circular queue with duplicate removal.
`default_nettype none

// Circular FIFO of DEPTH words with enqueue, dequeue and dedup commands.
// A command transfer happens at a rising edge with i_start high and o_busy
// low. Every command yields exactly one result, shown on o_out for a single
// cycle with o_strobe high; there is no back-pressure, the receiver must
// take it in that cycle. Enqueue, dequeue and the unused opcode pass through
// the execute state after the transfer edge, and the result is strobed
// in the following cycle, during which o_busy is already low so the next
// command can be taken. Dedup on an empty queue behaves the same way.
// Dedup on a queue holding F words keeps o_busy high while it walks the
// F words from the head: each word is read and captured, then compared
// against the kept words one at a time up to a match or the last kept
// word, and appended to the kept bank when none matches; a final state
// swaps the banks and strobes the result.
// The walk is paced by the single read port of the word store, which
// serves one source or kept word per cycle. Survivors are written to the
// second bank of the store, which becomes the live queue with head at
// slot 0 when the walk ends. Words are stored as their low DATA_WIDTH bits;
// a dequeued word is returned zero-extended or truncated to 32 bits. The
// store has no reset; only words that were enqueued are ever used.

module circular_queue_with_dedup_top #(
    parameter int DEPTH      = cqd_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cqd_pkg::DATA_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire cqd_pkg::t_in_item  i_in,
    output logic                    o_busy,
    output logic                    o_strobe,
    output cqd_pkg::t_out_item      o_out
);

    cqd_pkg::t_dp_cmd cmd;
    cqd_pkg::t_dp_sts sts;

    cqd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_opcode (i_in.opcode),
        .i_sts    (sts),
        .o_busy   (o_busy),
        .o_cmd    (cmd)
    );

    cqd_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_value  (i_in.value),
        .o_sts    (sts),
        .o_strobe (o_strobe),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

// ===== test/circular_queue_with_dedup_checker.sv =====
// Result checker for the circular queue with dedup: tracks queue state and compares results.
`default_nettype none

module circular_queue_with_dedup_checker
    import cqd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_start,
    input  wire logic      i_busy,
    input  wire t_in_item  i_in,
    input  wire logic      i_strobe,
    input  wire t_out_item i_out,
    output int             o_fail_cnt,
    output int             o_outstanding,
    output int             o_checked
);

    localparam int QDEPTH = DEPTH_DEF;

    // shadow copy of the queue
    logic [31:0] shadow_store [QDEPTH];
    logic [3:0]  shadow_head;
    logic [3:0]  shadow_tail;
    logic [4:0]  shadow_fill;

    t_out_item   pending_results [$];

    // first occurrence of each word survives, compacted from slot 0
    function automatic void dedup_shadow();
        logic [31:0] survivors [QDEPTH];
        int          kept;
        int          n;
        int          k;
        logic [3:0]  idx;
        bit          dup;
        kept = 0;
        idx  = shadow_head;
        for (n = 0; n < int'(shadow_fill); n++) begin
            dup = 1'b0;
            for (k = 0; k < kept; k++) begin
                if (survivors[k] == shadow_store[idx]) dup = 1'b1;
            end
            if (!dup) begin
                survivors[kept] = shadow_store[idx];
                kept++;
            end
            idx = idx + 4'd1;
        end
        for (k = 0; k < kept; k++) shadow_store[k] = survivors[k];
        shadow_head = '0;
        shadow_tail = kept[3:0];
        shadow_fill = kept[4:0];
    endfunction

    function automatic t_out_item queue_result(input t_in_item cmd);
        t_out_item r;
        r = '0;
        case (cmd.opcode)
            OP_ENQ: begin
                if (shadow_fill >= QDEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_store[shadow_tail] = cmd.value;
                    shadow_tail = shadow_tail + 4'd1;
                    shadow_fill = shadow_fill + 5'd1;
                end
            end
            OP_DEQ: begin
                if (shadow_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.value_res = shadow_store[shadow_head];
                    shadow_head = shadow_head + 4'd1;
                    shadow_fill = shadow_fill - 5'd1;
                end
            end
            OP_DEDUP: begin
                if (shadow_fill == 0) r.status = ST_EMPTY;
                else dedup_shadow();
            end
            default: ;  // unused opcode: no effect
        endcase
        r.count = shadow_fill;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item exp_r;
        int        fails;
        fails = o_fail_cnt;
        if (!i_rst_n) begin
            shadow_head = '0;
            shadow_tail = '0;
            shadow_fill = '0;
            pending_results.delete();
            o_fail_cnt    <= 0;
            o_outstanding <= 0;
            o_checked     <= 0;
        end else begin
            // a result in this cycle always belongs to an earlier transfer
            if (i_strobe) begin
                if (pending_results.size() == 0) begin
                    $error("result with no command outstanding: value_res %0d status %0d count %0d",
                           i_out.value_res, i_out.status, i_out.count);
                    fails++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (i_out.value_res !== exp_r.value_res) begin
                        $error("value_res mismatch: expected %0d, actual %0d",
                               exp_r.value_res, i_out.value_res);
                        fails++;
                    end
                    if (i_out.status !== exp_r.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               exp_r.status, i_out.status);
                        fails++;
                    end
                    if (i_out.count !== exp_r.count) begin
                        $error("count mismatch: expected %0d, actual %0d",
                               exp_r.count, i_out.count);
                        fails++;
                    end
                    o_checked <= o_checked + 1;
                end
            end
            if (i_start && !i_busy) pending_results.push_back(queue_result(i_in));
            o_fail_cnt    <= fails;
            o_outstanding <= pending_results.size();
        end
    end

endmodule

`default_nettype wire

// ===== test/circular_queue_with_dedup_top_test.sv =====
// Testbench top for the circular queue with dedup: stimulus, clock, reset and verdict.
`default_nettype none

module circular_queue_with_dedup_top_test;
    import cqd_pkg::*;

    // The package names only the three real commands; the fourth code is a no-op.
    localparam logic [1:0] OP_NOP = 2'd3;

    // Worst dedup walk is 16 distinct words on a full queue, so ~500 such
    // commands with long gaps stay far below this bound.
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_ITEMS  = 450;
    localparam int TAIL_CYCLES   = 20;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_start;
    t_in_item  i_in;
    logic      o_busy;
    logic      o_strobe;
    t_out_item o_out;

    int fail_cnt;
    int outstanding;
    int checked;
    int cycle_cnt;
    int op_cnt [4];

    circular_queue_with_dedup_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_in     (i_in),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_out    (o_out)
    );

    circular_queue_with_dedup_checker result_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_busy        (o_busy),
        .i_in          (i_in),
        .i_strobe      (o_strobe),
        .i_out         (o_out),
        .o_fail_cnt    (fail_cnt),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still outstanding",
                     cycle_cnt, outstanding);
            $display("status: fail");
            $finish;
        end
    end

    // Drive one command from the falling edge and hold it until the
    // transfer edge (start high, busy low).
    task automatic send_cmd(input logic [1:0] op, input logic [31:0] val);
        t_in_item cmd;
        cmd.opcode = op;
        cmd.value  = val;
        @(negedge i_clk);
        i_start <= 1'b1;
        i_in    <= cmd;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        op_cnt[op]++;
    endtask

    // Lower start for a number of cycles; junk on the payload meanwhile.
    task automatic idle_cycles(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            i_in    <= t_in_item'({$urandom_range(3), $urandom});
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Hold off until every result owed so far has come back.
    task automatic drain_results();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    // Opcode mix per batch: 0 leans toward filling, 1 toward draining,
    // anything else is balanced. Dedup and the no-op stay fairly rare.
    function automatic logic [1:0] pick_op(input int lean);
        int r;
        int enq_cut;
        int deq_cut;
        r = $urandom_range(99);
        enq_cut = (lean == 0) ? 65 : (lean == 1) ? 25 : 45;
        deq_cut = (lean == 0) ? 85 : 82;
        if (r < enq_cut) return OP_ENQ;
        if (r < deq_cut) return OP_DEQ;
        if (r < 96)      return OP_DEDUP;
        return OP_NOP;
    endfunction

    // Words for a batch's small pool; extremes show up now and then.
    function automatic logic [31:0] pool_word();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] word_pool [4];
        logic [31:0] fill_words [16];
        logic [1:0]  op;
        logic [31:0] val;
        int          sent;
        int          batch_len;
        int          lean;
        bit          no_gaps;
        bit          drained_mid;
        int          r;
        int          i;

        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_in        = '0;
        cycle_cnt   = 0;
        op_cnt      = '{default: 0};
        sent        = 0;
        drained_mid = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- Directed part ----
        // Empty-queue cases first: dequeue and dedup both report empty.
        send_cmd(OP_DEQ, 32'hFFFF_FFFF);
        send_cmd(OP_DEDUP, 32'h0);
        send_cmd(OP_NOP, 32'h1234_5678);

        // Fill to the brim with extremes and repeats, including repeats of
        // the first word and words separated by others.
        fill_words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                       32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 32'h0000_0005,
                       32'h0000_0005, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001,
                       32'h8000_0000, 32'hAAAA_AAAA, 32'h0000_0000, 32'h8000_0001};
        for (i = 0; i < 16; i++) send_cmd(OP_ENQ, fill_words[i]);

        // Enqueue into a full queue, then the no-op at full count.
        send_cmd(OP_ENQ, 32'h0BAD_F00D);
        send_cmd(OP_NOP, 32'h0);
        // Dedup compacts to slot 0; dequeues then read from the new head.
        send_cmd(OP_DEDUP, 32'h0);
        send_cmd(OP_DEQ, 32'h0);
        send_cmd(OP_DEQ, 32'h0);

        // Sender pause: nothing goes out until the directed results are in.
        drain_results();

        // ---- Random part ----
        // Batches lean toward filling or draining or are balanced, so the queue
        // sweeps between empty and full and head/tail wrap before dedups.
        while (sent < RANDOM_ITEMS) begin
            batch_len = $urandom_range(15, 40);
            lean      = $urandom_range(2);
            no_gaps   = ($urandom_range(9) < 3);
            for (i = 0; i < 4; i++) word_pool[i] = pool_word();

            for (i = 0; i < batch_len; i++) begin
                op = pick_op(lean);
                // mostly pool words so dedup finds duplicates
                val = ($urandom_range(9) < 6) ? word_pool[$urandom_range(3)] : $urandom;
                send_cmd(op, val);
                sent++;
                if (!no_gaps) begin
                    r = $urandom_range(99);
                    if (r >= 92)      idle_cycles($urandom_range(10, 40));
                    else if (r >= 70) idle_cycles($urandom_range(1, 3));
                end
            end

            if (!drained_mid && sent >= RANDOM_ITEMS / 2) begin
                drain_results();
                drained_mid = 1'b1;
            end
        end

        // ---- Wind-down ----
        drain_results();
        // an idle tail to catch any stray strobe
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d enqueue, %0d dequeue, %0d dedup and %0d no-op commands",
                 op_cnt[OP_ENQ], op_cnt[OP_DEQ], op_cnt[OP_DEDUP], op_cnt[OP_NOP]);
        $display("%0d results compared in %0d cycles, %0d failures",
                 checked, cycle_cnt, fail_cnt);
        if (fail_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
sv/cqd_pkg.sv
sv/cqd_ctrl.sv
sv/cqd_dp.sv
sv/circular_queue_with_dedup_top.sv
test/circular_queue_with_dedup_checker.sv
test/circular_queue_with_dedup_top_test.sv
